// ----- hdl/nwti_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nwti_pkg
// Shared constants and types of the Indian-numbering word speller.
// ----------------------------------------------------------------------------
package nwti_pkg;

    localparam int VALUE_W       = 30;
    localparam int CODE_W        = 5;
    localparam int NUM_DIGITS    = 9;
    localparam int BCD_W         = 4 * NUM_DIGITS;
    localparam int NUM_GROUPS    = 5;
    localparam int SLOTS_PER_GRP = 3;
    localparam int NUM_SLOTS     = NUM_GROUPS * SLOTS_PER_GRP;
    localparam int BITS_PER_STEP = 3;
    localparam int NUM_STEPS     = VALUE_W / BITS_PER_STEP;
    localparam int STEP_W        = $clog2(NUM_STEPS + 1);
    localparam int QUEUE_DEPTH   = 2;
    localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

    localparam logic [VALUE_W-1:0] DECIMAL_MOD = VALUE_W'(1000000000);

    localparam logic [CODE_W-1:0] WORD_HUNDRED  = 5'd27;
    localparam logic [CODE_W-1:0] WORD_THOUSAND = 5'd28;
    localparam logic [CODE_W-1:0] WORD_LAKH     = 5'd29;
    localparam logic [CODE_W-1:0] WORD_CRORE    = 5'd30;

    // One spelled number: a bit per word slot and the code of each slot.
    // Slot order is group by group, high group first, each group as
    // first word, second word, scale word.
    typedef struct packed {
        logic [NUM_SLOTS-1:0]             mask;
        logic [NUM_SLOTS-1:0][CODE_W-1:0] codes;
    } desc_t;

endpackage

`default_nettype wire

// ----- hdl/number_to_word_tokens_indian_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// number_to_word_tokens_indian_core
// Spells a number modulo 10^9 in the Indian numbering system as word codes.
//
// Channel   Ports                         Transfer when
// input     value, push, full             push && !full
// result    word_code, last_word, empty,  pop && !empty
//           pop
//
// The modulo reduction is done on the accepting edge. The front is then busy
// converting the number three bits per step, then hands it to the queue,
// and takes no new number until the queue has taken it. The back gives one
// word per cycle while the consumer pops, up to 13 words per number. It
// needs a separate load only when it was idle; a queued number loads
// on the transfer of the previous number's last word. A two-entry queue lets
// the front convert while the back is stalled by the consumer. Reset clears
// all control state; there is no clearing pass.
// ----------------------------------------------------------------------------
module number_to_word_tokens_indian_core (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic [nwti_pkg::VALUE_W-1:0]   value,
    input  wire logic                           push,
    output logic                                full,
    output logic [nwti_pkg::CODE_W-1:0]         word_code,
    output logic                                last_word,
    output logic                                empty,
    input  wire logic                           pop
);

    logic            q_push;
    logic            q_full;
    logic            q_pop;
    logic            q_valid;
    nwti_pkg::desc_t q_wdata;
    nwti_pkg::desc_t q_rdata;

    nwti_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .value   (value),
        .push    (push),
        .full    (full),
        .q_push  (q_push),
        .q_wdata (q_wdata),
        .q_full  (q_full)
    );

    nwti_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wdata   (q_wdata),
        .q_full  (q_full),
        .rd_en   (q_pop),
        .q_valid (q_valid),
        .rdata   (q_rdata)
    );

    nwti_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_rdata   (q_rdata),
        .q_pop     (q_pop),
        .word_code (word_code),
        .last_word (last_word),
        .empty     (empty),
        .pop       (pop)
    );

endmodule

`default_nettype wire

// ----- hdl/nwti_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nwti_front
// Accepts a number, reduces it modulo 10^9, converts it to decimal digits
// three bits a cycle and classifies the digit groups into word slots.
// ----------------------------------------------------------------------------
module nwti_front (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic [nwti_pkg::VALUE_W-1:0]          value,
    input  wire logic                                  push,
    output logic                                       full,
    output logic                                       q_push,
    output nwti_pkg::desc_t                            q_wdata,
    input  wire logic                                  q_full
);

    logic                                busy_reg, busy_next;
    logic [nwti_pkg::STEP_W-1:0]         step_reg, step_next;
    logic [nwti_pkg::VALUE_W-1:0]        bin_reg, bin_next;
    logic [nwti_pkg::BCD_W-1:0]          bcd_reg, bcd_next;
    logic                                accept;
    logic                                done;
    logic [nwti_pkg::VALUE_W-1:0]        reduced;
    logic [nwti_pkg::BCD_W-1:0]          bcd_stepped;
    logic [nwti_pkg::NUM_GROUPS-1:0][3:0] tens;
    logic [nwti_pkg::NUM_GROUPS-1:0][3:0] units;
    logic [nwti_pkg::NUM_GROUPS-1:0][nwti_pkg::CODE_W-1:0] scale_code;

    // One shift-and-add-3 step of the binary to decimal conversion.
    function automatic logic [nwti_pkg::BCD_W-1:0] dabble(
        input logic [nwti_pkg::BCD_W-1:0] bcd,
        input logic                       bit_in
    );
        logic [nwti_pkg::BCD_W-1:0] adj;
        adj = bcd;
        for (int i = 0; i < nwti_pkg::NUM_DIGITS; i++) begin
            if (bcd[4*i +: 4] >= 4'd5) begin
                adj[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
            end
        end
        return {adj[nwti_pkg::BCD_W-2:0], bit_in};
    endfunction

    assign accept  = push && !busy_reg;
    assign full    = busy_reg;
    assign done    = busy_reg && (step_reg == nwti_pkg::STEP_W'(nwti_pkg::NUM_STEPS));
    assign q_push  = done;
    assign reduced = (value >= nwti_pkg::DECIMAL_MOD) ? (value - nwti_pkg::DECIMAL_MOD)
                                                       : value;

    always_comb
    begin
        bcd_stepped = bcd_reg;
        for (int b = 0; b < nwti_pkg::BITS_PER_STEP; b++) begin
            bcd_stepped = dabble(bcd_stepped, bin_reg[nwti_pkg::VALUE_W-1-b]);
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        step_next = step_reg;
        bin_next  = bin_reg;
        bcd_next  = bcd_reg;
        if (accept) begin
            busy_next = 1'b1;
            step_next = '0;
            bin_next  = reduced;
            bcd_next  = '0;
        end else if (busy_reg && !done) begin
            step_next = step_reg + 1'b1;
            bin_next  = bin_reg << nwti_pkg::BITS_PER_STEP;
            bcd_next  = bcd_stepped;
        end else if (done && !q_full) begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
    end

    // Digit groups: crore, lakh, thousand, hundred, final two digits.
    assign tens[0]  = bcd_reg[35:32];
    assign units[0] = bcd_reg[31:28];
    assign tens[1]  = bcd_reg[27:24];
    assign units[1] = bcd_reg[23:20];
    assign tens[2]  = bcd_reg[19:16];
    assign units[2] = bcd_reg[15:12];
    assign tens[3]  = 4'd0;
    assign units[3] = bcd_reg[11:8];
    assign tens[4]  = bcd_reg[7:4];
    assign units[4] = bcd_reg[3:0];

    assign scale_code[0] = nwti_pkg::WORD_CRORE;
    assign scale_code[1] = nwti_pkg::WORD_LAKH;
    assign scale_code[2] = nwti_pkg::WORD_THOUSAND;
    assign scale_code[3] = nwti_pkg::WORD_HUNDRED;
    assign scale_code[4] = nwti_pkg::WORD_HUNDRED;

    always_comb
    begin
        logic nonzero;
        logic big;
        int   s;
        q_wdata = '0;
        for (int g = 0; g < nwti_pkg::NUM_GROUPS; g++) begin
            s       = g * nwti_pkg::SLOTS_PER_GRP;
            nonzero = (tens[g] != 4'd0) || (units[g] != 4'd0);
            big     = (tens[g] >= 4'd2);
            if (big) begin
                q_wdata.codes[s] = {1'b0, tens[g]} + 5'd17;
            end else if (tens[g][0]) begin
                q_wdata.codes[s] = {1'b0, units[g]} + 5'd9;
            end else begin
                q_wdata.codes[s] = {1'b0, units[g]} - 5'd1;
            end
            q_wdata.codes[s+1] = {1'b0, units[g]} - 5'd1;
            q_wdata.codes[s+2] = scale_code[g];
            q_wdata.mask[s]    = nonzero;
            q_wdata.mask[s+1]  = big && (units[g] != 4'd0);
            // The final two digits carry no scale word.
            q_wdata.mask[s+2]  = nonzero && (g != nwti_pkg::NUM_GROUPS - 1);
        end
    end

endmodule

`default_nettype wire

// ----- hdl/nwti_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nwti_queue
// Short queue of classified numbers between the front and the back.
// ----------------------------------------------------------------------------
module nwti_queue (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            wr_en,
    input  wire nwti_pkg::desc_t wdata,
    output logic                 q_full,
    input  wire logic            rd_en,
    output logic                 q_valid,
    output nwti_pkg::desc_t      rdata
);

    nwti_pkg::desc_t                 entries_reg [nwti_pkg::QUEUE_DEPTH];
    logic [nwti_pkg::QPTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [nwti_pkg::QPTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [nwti_pkg::QCNT_W-1:0]     count_reg, count_next;
    logic                            do_wr;
    logic                            do_rd;

    assign q_full  = (count_reg == nwti_pkg::QCNT_W'(nwti_pkg::QUEUE_DEPTH));
    assign q_valid = (count_reg != '0);
    assign do_wr   = wr_en && !q_full;
    assign do_rd   = rd_en && q_valid;
    assign rdata   = entries_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr) begin
            wr_ptr_next = (wr_ptr_reg == nwti_pkg::QPTR_W'(nwti_pkg::QUEUE_DEPTH - 1))
                          ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd) begin
            rd_ptr_next = (rd_ptr_reg == nwti_pkg::QPTR_W'(nwti_pkg::QUEUE_DEPTH - 1))
                          ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd) begin
            count_next = count_reg + 1'b1;
        end else if (do_rd && !do_wr) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr) begin
            entries_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/nwti_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nwti_back
// Holds one classified number and hands out its words, one per transfer,
// in slot order.
// ----------------------------------------------------------------------------
module nwti_back (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          q_valid,
    input  wire nwti_pkg::desc_t               q_rdata,
    output logic                               q_pop,
    output logic [nwti_pkg::CODE_W-1:0]        word_code,
    output logic                               last_word,
    output logic                               empty,
    input  wire logic                          pop
);

    logic [nwti_pkg::NUM_SLOTS-1:0]                   mask_reg, mask_next;
    logic [nwti_pkg::NUM_SLOTS-1:0][nwti_pkg::CODE_W-1:0] codes_reg, codes_next;
    logic [nwti_pkg::NUM_SLOTS-1:0]                   low_bit;
    logic [nwti_pkg::NUM_SLOTS-1:0]                   rest;
    logic                                             xfer;

    assign low_bit   = mask_reg & (~mask_reg + 1'b1);
    assign rest      = mask_reg & ~low_bit;
    assign empty     = (mask_reg == '0);
    assign last_word = (rest == '0);
    assign xfer      = pop && !empty;
    // A number with no words is loaded and dropped on the next cycle.
    assign q_pop     = q_valid && (empty || (xfer && last_word));

    always_comb
    begin
        word_code = '0;
        for (int i = 0; i < nwti_pkg::NUM_SLOTS; i++) begin
            word_code = word_code | (codes_reg[i] & {nwti_pkg::CODE_W{low_bit[i]}});
        end
    end

    always_comb
    begin
        mask_next  = mask_reg;
        codes_next = codes_reg;
        if (q_pop) begin
            mask_next  = q_rdata.mask;
            codes_next = q_rdata.codes;
        end else if (xfer) begin
            mask_next  = rest;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mask_reg <= '0;
        end else begin
            mask_reg <= mask_next;
        end
    end

    always_ff @(posedge clk)
    begin
        codes_reg <= codes_next;
    end

endmodule

`default_nettype wire
